### src/assert_macros.svh
// assertion macros used by the checker file su2qa_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is low
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion, also checked during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/su2qa_pkg.sv
package su2qa_pkg;

    localparam logic [2:0] CMD_SUM   = 3'd0;
    localparam logic [2:0] CMD_MUL   = 3'd1;
    localparam logic [2:0] CMD_SCALE = 3'd2;
    localparam logic [2:0] CMD_CONJ  = 3'd3;
    localparam logic [2:0] CMD_DET   = 3'd4;
    localparam logic [2:0] CMD_TRACE = 3'd5;

    localparam int unsigned NUM_LANES  = 4;
    localparam int unsigned NUM_TERMS  = 4;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_PTR_W = 3;
    localparam int unsigned OCC_W      = 4;

    typedef struct packed {
        logic                 vld;
        logic                 mul;
        logic [NUM_TERMS-1:0] neg;
    } t_lane_ctrl;

endpackage

### src/su2qa_if.sv
interface su2qa_req_if #(
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           command;
    logic signed [DW-1:0] b0;
    logic signed [DW-1:0] b1;
    logic signed [DW-1:0] b2;
    logic signed [DW-1:0] b3;
    logic signed [DW-1:0] c0;
    logic signed [DW-1:0] c1;
    logic signed [DW-1:0] c2;
    logic signed [DW-1:0] c3;
    logic signed [DW-1:0] k_real;
    logic signed [DW-1:0] k_imag;

    modport source (
        output valid, command, b0, b1, b2, b3, c0, c1, c2, c3, k_real, k_imag,
        input  ready
    );
    modport sink (
        input  valid, command, b0, b1, b2, b3, c0, c1, c2, c3, k_real, k_imag,
        output ready
    );
endinterface

interface su2qa_rsp_if #(
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r0;
    logic signed [DW-1:0] r1;
    logic signed [DW-1:0] r2;
    logic signed [DW-1:0] r3;
    logic                 overflow;

    modport source (
        output valid, r0, r1, r2, r3, overflow,
        input  ready
    );
    modport sink (
        input  valid, r0, r1, r2, r3, overflow,
        output ready
    );
endinterface

### src/su2qa_lane.sv
module su2qa_lane #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  su2qa_pkg::t_lane_ctrl        i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_x [su2qa_pkg::NUM_TERMS],
    input  logic signed [DATA_WIDTH-1:0] i_y [su2qa_pkg::NUM_TERMS],
    input  logic signed [DATA_WIDTH:0]   i_lin,
    output logic                         o_vld,
    output logic signed [DATA_WIDTH-1:0] o_r,
    output logic                         o_ovf
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 2;
    localparam int NT = su2qa_pkg::NUM_TERMS;

    // stage 1: products
    logic                 r_v1;
    logic                 r_mul1;
    logic [NT-1:0]        r_neg1;
    logic signed [PW-1:0] r_p1 [NT];
    logic signed [DATA_WIDTH:0] r_lin1;

    // stage 2: exact sum, truncated
    logic                 r_v2;
    logic signed [SW-1:0] r_s2;
    logic signed [SW-1:0] n_s2;
    logic signed [SW-1:0] w_term [NT];
    logic signed [SW-1:0] w_sum;

    // stage 3: saturated
    logic                         r_v3;
    logic signed [DATA_WIDTH-1:0] r_r3;
    logic                         r_ovf3;
    logic signed [DATA_WIDTH-1:0] n_r3;
    logic                         n_ovf3;
    logic [SW-DATA_WIDTH:0]       w_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul1 <= i_ctrl.mul;
        r_neg1 <= i_ctrl.neg;
        r_lin1 <= i_lin;
        for (int k = 0; k < NT; k++) begin
            r_p1[k] <= PW'(i_x[k]) * PW'(i_y[k]);
        end
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NT; k++) begin
            w_term[k] = r_neg1[k] ? -SW'(r_p1[k]) : SW'(r_p1[k]);
            w_sum     = w_sum + w_term[k];
        end
        n_s2 = r_mul1 ? (w_sum >>> FRAC_BITS) : SW'(r_lin1);
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    always_comb begin
        w_top  = r_s2[SW-1:DATA_WIDTH-1];
        n_ovf3 = !((&w_top) || !(|w_top));
        if (!n_ovf3) begin
            n_r3 = r_s2[DATA_WIDTH-1:0];
        end else if (r_s2[SW-1]) begin
            n_r3 = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            n_r3 = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_r3   <= n_r3;
        r_ovf3 <= n_ovf3;
    end

    assign o_vld = r_v3;
    assign o_r   = r_r3;
    assign o_ovf = r_ovf3;

endmodule

### src/su2qa_merge.sv
module su2qa_merge #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic signed [DATA_WIDTH-1:0] i_r [su2qa_pkg::NUM_LANES],
    input  logic [su2qa_pkg::NUM_LANES-1:0] i_ovf,
    output logic                         o_pop,
    su2qa_rsp_if.source                  o_rsp
);

    localparam int PW = 4 * DATA_WIDTH + 1;

    logic [PW-1:0]                      r_mem [su2qa_pkg::FIFO_DEPTH];
    logic [su2qa_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [su2qa_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [su2qa_pkg::OCC_W-1:0]        r_cnt;
    logic [su2qa_pkg::OCC_W-1:0]        n_cnt;
    logic [PW-1:0]                      w_wr_data;
    logic [PW-1:0]                      w_rd_data;

    // combine lanes: overflow if any lane saturated
    assign w_wr_data = {(|i_ovf), i_r[3], i_r[2], i_r[1], i_r[0]};
    assign w_rd_data = r_mem[r_rd_ptr];
    assign o_pop     = o_rsp.valid && o_rsp.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_vld && !o_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_vld && o_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (o_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_mem[r_wr_ptr] <= w_wr_data;
        end
    end

    assign o_rsp.valid    = (r_cnt != '0);
    assign o_rsp.r0       = w_rd_data[DATA_WIDTH-1:0];
    assign o_rsp.r1       = w_rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
    assign o_rsp.r2       = w_rd_data[3*DATA_WIDTH-1:2*DATA_WIDTH];
    assign o_rsp.r3       = w_rd_data[4*DATA_WIDTH-1:3*DATA_WIDTH];
    assign o_rsp.overflow = w_rd_data[PW-1];

endmodule

### src/su2_quaternion_alu_top.sv
// channel   dir   handshake       payload
// i_req     in    valid/ready     command, b0..b3, c0..c3, k_real, k_imag
// o_rsp     out   valid/ready     r0..r3, overflow
//
// one request per cycle while i_req.ready is high; a result reaches o_rsp once its
// request has passed three lane stages (multiply, exact sum, saturate) and the queue write
// an eight-entry result queue holds finished results; i_req.ready drops when
// eight requests are in flight or queued, so a stalled o_rsp backs up to i_req
// synchronous active-low reset empties the pipeline and the queue
module su2_quaternion_alu_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    su2qa_req_if.sink   i_req,
    su2qa_rsp_if.source o_rsp
);

    localparam int NL = su2qa_pkg::NUM_LANES;
    localparam int NT = su2qa_pkg::NUM_TERMS;
    localparam int DW = DATA_WIDTH;

    logic                   w_acc;
    logic                   w_pop;
    logic [su2qa_pkg::OCC_W-1:0] r_occ;
    logic [su2qa_pkg::OCC_W-1:0] n_occ;

    logic signed [DW-1:0]   w_b [4];
    logic signed [DW-1:0]   w_c [4];
    logic signed [DW-1:0]   w_x [NL][NT];
    logic signed [DW-1:0]   w_y [NL][NT];
    logic signed [DW:0]     w_lin [NL];
    su2qa_pkg::t_lane_ctrl  w_ctrl [NL];

    logic                   w_vld [NL];
    logic signed [DW-1:0]   w_r [NL];
    logic [NL-1:0]          w_ovf;

    assign w_acc       = i_req.valid && i_req.ready;
    assign i_req.ready = (r_occ < su2qa_pkg::OCC_W'(su2qa_pkg::FIFO_DEPTH));

    always_comb begin
        n_occ = r_occ;
        if (w_acc && !w_pop) begin
            n_occ = r_occ + 1'b1;
        end else if (!w_acc && w_pop) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign w_b[0] = i_req.b0;
    assign w_b[1] = i_req.b1;
    assign w_b[2] = i_req.b2;
    assign w_b[3] = i_req.b3;
    assign w_c[0] = i_req.c0;
    assign w_c[1] = i_req.c1;
    assign w_c[2] = i_req.c2;
    assign w_c[3] = i_req.c3;

    // operand routing per lane
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_lin[l]      = '0;
            w_ctrl[l].vld = w_acc;
            w_ctrl[l].mul = 1'b0;
            w_ctrl[l].neg = '0;
            for (int k = 0; k < NT; k++) begin
                w_x[l][k] = '0;
                w_y[l][k] = '0;
            end
        end
        case (i_req.command)
            su2qa_pkg::CMD_SUM: begin
                for (int l = 0; l < NL; l++) begin
                    w_lin[l] = (DW+1)'(w_b[l]) + (DW+1)'(w_c[l]);
                end
            end
            su2qa_pkg::CMD_MUL: begin
                for (int l = 0; l < NL; l++) begin
                    w_ctrl[l].mul = 1'b1;
                end
                w_x[0] = '{w_b[0], w_b[3], w_b[2], w_b[1]};
                w_y[0] = '{w_c[0], w_c[3], w_c[2], w_c[1]};
                w_ctrl[0].neg = 4'b1110;
                w_x[1] = '{w_b[2], w_b[1], w_b[0], w_b[3]};
                w_y[1] = '{w_c[3], w_c[0], w_c[1], w_c[2]};
                w_ctrl[1].neg = 4'b0001;
                w_x[2] = '{w_b[0], w_b[3], w_b[2], w_b[1]};
                w_y[2] = '{w_c[2], w_c[1], w_c[0], w_c[3]};
                w_ctrl[2].neg = 4'b0010;
                w_x[3] = '{w_b[0], w_b[3], w_b[2], w_b[1]};
                w_y[3] = '{w_c[3], w_c[0], w_c[1], w_c[2]};
                w_ctrl[3].neg = 4'b1000;
            end
            su2qa_pkg::CMD_SCALE: begin
                for (int l = 0; l < NL; l++) begin
                    w_ctrl[l].mul = 1'b1;
                    w_x[l][0]     = i_req.k_real;
                    w_y[l][0]     = w_c[l];
                    w_x[l][1]     = i_req.k_imag;
                end
                w_y[0][1] = w_c[3];
                w_y[1][1] = w_c[2];
                w_y[2][1] = w_c[1];
                w_y[3][1] = w_c[0];
                w_ctrl[0].neg = 4'b0010;
                w_ctrl[1].neg = 4'b0010;
            end
            su2qa_pkg::CMD_CONJ: begin
                w_lin[0] = (DW+1)'(w_b[0]);
                for (int l = 1; l < NL; l++) begin
                    w_lin[l] = -((DW+1)'(w_b[l]));
                end
            end
            su2qa_pkg::CMD_DET: begin
                w_ctrl[0].mul = 1'b1;
                for (int k = 0; k < NT; k++) begin
                    w_x[0][k] = w_b[k];
                    w_y[0][k] = w_b[k];
                end
            end
            su2qa_pkg::CMD_TRACE: begin
                w_lin[0] = (DW+1)'(w_b[0]) + (DW+1)'(w_b[0]);
            end
            default: begin
            end
        endcase
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        su2qa_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[l]),
            .i_x     (w_x[l]),
            .i_y     (w_y[l]),
            .i_lin   (w_lin[l]),
            .o_vld   (w_vld[l]),
            .o_r     (w_r[l]),
            .o_ovf   (w_ovf[l])
        );
    end

    su2qa_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[0]),
        .i_r     (w_r),
        .i_ovf   (w_ovf),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

### src/su2qa_chk.sv
`include "assert_macros.svh"

module su2qa_chk #(
    parameter int DW = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input logic [DW-1:0] i_rsp_r0,
    input logic [DW-1:0] i_rsp_r1,
    input logic [DW-1:0] i_rsp_r2,
    input logic [DW-1:0] i_rsp_r3,
    input logic          i_rsp_overflow
);

    localparam logic [su2qa_pkg::OCC_W-1:0] CREDITS = su2qa_pkg::OCC_W'(su2qa_pkg::FIFO_DEPTH);

    // requests accepted and not yet delivered
    logic [su2qa_pkg::OCC_W-1:0] r_out;
    logic [su2qa_pkg::OCC_W-1:0] n_out;
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic [4*DW:0]               w_rsp;

    assign w_in_acc  = i_req_valid && i_req_ready;
    assign w_out_acc = i_rsp_valid && i_rsp_ready;
    assign w_rsp     = {i_rsp_r0, i_rsp_r1, i_rsp_r2, i_rsp_r3, i_rsp_overflow};

    always_comb begin
        n_out = r_out;
        if (w_in_acc && !w_out_acc) begin
            n_out = r_out + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            n_out = r_out - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            r_out <= n_out;
        end
    end

    `CHK_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_rsp_valid)
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(w_rsp))
    `CHK_ASSERT(a_no_orphan, i_clk, i_rst_n, i_rsp_valid |-> r_out != '0)
    `CHK_ASSERT(a_credit, i_clk, i_rst_n, i_req_ready == (r_out < CREDITS))

endmodule

bind su2_quaternion_alu_top su2qa_chk #(
    .DW (DATA_WIDTH)
) u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_r0       (o_rsp.r0),
    .i_rsp_r1       (o_rsp.r1),
    .i_rsp_r2       (o_rsp.r2),
    .i_rsp_r3       (o_rsp.r3),
    .i_rsp_overflow (o_rsp.overflow)
);

### test/su2_quaternion_alu_checker.sv
module su2_quaternion_alu_checker #(
    parameter int DW = 32,
    parameter int FB = 28
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    su2qa_req_if  i_req,
    su2qa_rsp_if  i_rsp,
    output int    o_mismatch_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WW = 2 * DW + 4;
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] r0;
        logic signed [DW-1:0] r1;
        logic signed [DW-1:0] r2;
        logic signed [DW-1:0] r3;
        logic                 overflow;
    } t_quat_result;

    t_quat_result expected_results[$];

    function automatic t_quat_result predict_quat(
        input logic [2:0]           cmd,
        input logic signed [DW-1:0] b [4],
        input logic signed [DW-1:0] c [4],
        input logic signed [DW-1:0] kr,
        input logic signed [DW-1:0] ki
    );
        logic signed [WW-1:0] bw [4];
        logic signed [WW-1:0] cw [4];
        logic signed [WW-1:0] a [4];
        logic signed [WW-1:0] krw;
        logic signed [WW-1:0] kiw;
        logic signed [DW-1:0] r [4];
        logic                 ovf;
        t_quat_result         res;
        for (int i = 0; i < 4; i++) begin
            bw[i] = b[i];
            cw[i] = c[i];
            a[i]  = '0;
        end
        krw = kr;
        kiw = ki;
        case (cmd)
            su2qa_pkg::CMD_SUM: begin
                for (int i = 0; i < 4; i++) a[i] = bw[i] + cw[i];
            end
            su2qa_pkg::CMD_MUL: begin
                a[0] = (bw[0]*cw[0] - bw[3]*cw[3] - bw[2]*cw[2] - bw[1]*cw[1]) >>> FB;
                a[1] = (bw[1]*cw[0] + bw[0]*cw[1] + bw[3]*cw[2] - bw[2]*cw[3]) >>> FB;
                a[2] = (bw[0]*cw[2] - bw[3]*cw[1] + bw[2]*cw[0] + bw[1]*cw[3]) >>> FB;
                a[3] = (bw[0]*cw[3] + bw[3]*cw[0] + bw[2]*cw[1] - bw[1]*cw[2]) >>> FB;
            end
            su2qa_pkg::CMD_SCALE: begin
                a[0] = (krw*cw[0] - kiw*cw[3]) >>> FB;
                a[1] = (krw*cw[1] - kiw*cw[2]) >>> FB;
                a[2] = (krw*cw[2] + kiw*cw[1]) >>> FB;
                a[3] = (krw*cw[3] + kiw*cw[0]) >>> FB;
            end
            su2qa_pkg::CMD_CONJ: begin
                a[0] = bw[0];
                for (int i = 1; i < 4; i++) a[i] = -bw[i];
            end
            su2qa_pkg::CMD_DET: begin
                a[0] = (bw[0]*bw[0] + bw[1]*bw[1] + bw[2]*bw[2] + bw[3]*bw[3]) >>> FB;
            end
            su2qa_pkg::CMD_TRACE: begin
                a[0] = bw[0] + bw[0];
            end
            default: begin
            end
        endcase
        ovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if ((&a[i][WW-1:DW-1]) || !(|a[i][WW-1:DW-1])) begin
                r[i] = a[i][DW-1:0];
            end else begin
                r[i] = a[i][WW-1] ? SAT_MIN : SAT_MAX;
                ovf  = 1'b1;
            end
        end
        res.r0       = r[0];
        res.r1       = r[1];
        res.r2       = r[2];
        res.r3       = r[3];
        res.overflow = ovf;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        logic signed [DW-1:0] b_arr [4];
        logic signed [DW-1:0] c_arr [4];
        t_quat_result         want;
        t_quat_result         got;
        if (!i_rst_n) begin
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                b_arr[0] = i_req.b0;
                b_arr[1] = i_req.b1;
                b_arr[2] = i_req.b2;
                b_arr[3] = i_req.b3;
                c_arr[0] = i_req.c0;
                c_arr[1] = i_req.c1;
                c_arr[2] = i_req.c2;
                c_arr[3] = i_req.c3;
                expected_results.push_back(predict_quat(i_req.command, b_arr, c_arr,
                                                        i_req.k_real, i_req.k_imag));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.r0       = i_rsp.r0;
                got.r1       = i_rsp.r1;
                got.r2       = i_rsp.r2;
                got.r3       = i_rsp.r3;
                got.overflow = i_rsp.overflow;
                if (expected_results.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= 10)
                        $display("unexpected result r0=%h r1=%h r2=%h r3=%h ovf=%b",
                                 got.r0, got.r1, got.r2, got.r3, got.overflow);
                end else begin
                    want = expected_results.pop_front();
                    if (want.r0 !== got.r0 || want.r1 !== got.r1 || want.r2 !== got.r2 ||
                        want.r3 !== got.r3 || want.overflow !== got.overflow) begin
                        o_mismatch_count++;
                        if (o_mismatch_count <= 10) begin
                            $display("mismatch exp r0=%h r1=%h r2=%h r3=%h ovf=%b",
                                     want.r0, want.r1, want.r2, want.r3, want.overflow);
                            $display("         got r0=%h r1=%h r2=%h r3=%h ovf=%b",
                                     got.r0, got.r1, got.r2, got.r3, got.overflow);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### test/su2_quaternion_alu_top_tb.sv
module su2_quaternion_alu_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW            = 32;
    localparam int FB            = 28;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_GAP       = 17;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam logic signed [DW-1:0] VAL_MAX  = 32'sh7fffffff;
    localparam logic signed [DW-1:0] VAL_MIN  = 32'sh80000000;
    localparam logic signed [DW-1:0] VAL_ONE  = 32'sh10000000;
    localparam logic signed [DW-1:0] VAL_ZERO = 32'sh00000000;

    typedef struct {
        logic [2:0]           command;
        logic signed [DW-1:0] b [4];
        logic signed [DW-1:0] c [4];
        logic signed [DW-1:0] k_real;
        logic signed [DW-1:0] k_imag;
    } t_quat_request;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   pending_results;
    int   cycle_count;
    bit   sender_burst;
    bit   sink_burst;

    su2qa_req_if #(.DW(DW)) req_if ();
    su2qa_rsp_if #(.DW(DW)) rsp_if ();

    su2_quaternion_alu_top #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    su2_quaternion_alu_checker #(
        .DW (DW),
        .FB (FB)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req            (req_if),
        .i_rsp            (rsp_if),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // style 0 full range, 1 unit-scale, 2 mixed per field, 3 mid-range
    function automatic logic signed [DW-1:0] rand_operand(input int style);
        int pick;
        pick = (style == 2) ? $urandom_range(0, 4) : style;
        case (pick)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
            3: return $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
            default: begin
                case ($urandom_range(0, 6))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return VAL_ZERO;
                    3: return VAL_ONE;
                    4: return -VAL_ONE;
                    5: return 32'sh00000001;
                    default: return 32'shffffffff;
                endcase
            end
        endcase
    endfunction

    function automatic t_quat_request rand_request();
        t_quat_request rq;
        int            style;
        style = $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0)
            rq.command = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        else
            rq.command = 3'($urandom_range(su2qa_pkg::CMD_SUM, su2qa_pkg::CMD_TRACE));
        for (int i = 0; i < 4; i++) begin
            rq.b[i] = rand_operand(style);
            rq.c[i] = rand_operand(style);
        end
        rq.k_real = rand_operand(style);
        rq.k_imag = rand_operand(style);
        return rq;
    endfunction

    function automatic t_quat_request fill_request(
        input logic [2:0]           cmd,
        input logic signed [DW-1:0] bv,
        input logic signed [DW-1:0] cv,
        input logic signed [DW-1:0] kv
    );
        t_quat_request rq;
        rq.command = cmd;
        for (int i = 0; i < 4; i++) begin
            rq.b[i] = bv;
            rq.c[i] = cv;
        end
        rq.k_real = kv;
        rq.k_imag = kv;
        return rq;
    endfunction

    task automatic send_request(input t_quat_request rq);
        int gap;
        req_if.valid   <= 1'b1;
        req_if.command <= rq.command;
        req_if.b0      <= rq.b[0];
        req_if.b1      <= rq.b[1];
        req_if.b2      <= rq.b[2];
        req_if.b3      <= rq.b[3];
        req_if.c0      <= rq.c[0];
        req_if.c1      <= rq.c[1];
        req_if.c2      <= rq.c[2];
        req_if.c3      <= rq.c[3];
        req_if.k_real  <= rq.k_real;
        req_if.k_imag  <= rq.k_imag;
        do @(posedge clk); while (!req_if.ready);
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** su2_quaternion_alu_top: FAILED **");
        $finish;
    end

    // result side
    initial begin
        int gap;
        int taken;
        taken = 0;
        sink_burst = 1'b0;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = draw_gap(sink_burst);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            taken++;
            if (taken % 128 == 0) sink_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // request side
    initial begin
        t_quat_request rq;
        sender_burst = 1'b0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.command <= su2qa_pkg::CMD_SUM;
        req_if.b0      <= '0;
        req_if.b1      <= '0;
        req_if.b2      <= '0;
        req_if.b3      <= '0;
        req_if.c0      <= '0;
        req_if.c1      <= '0;
        req_if.c2      <= '0;
        req_if.c3      <= '0;
        req_if.k_real  <= '0;
        req_if.k_imag  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation at both ends of the sum
        send_request(fill_request(su2qa_pkg::CMD_SUM, VAL_MAX, VAL_MAX, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_SUM, VAL_MIN, VAL_MIN, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_SUM, VAL_MAX, VAL_MIN, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_SUM, VAL_ZERO, VAL_ZERO, VAL_ZERO));
        // product extremes and identity
        send_request(fill_request(su2qa_pkg::CMD_MUL, VAL_MAX, VAL_MAX, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_MUL, VAL_MIN, VAL_MIN, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_MUL, VAL_MAX, VAL_MIN, VAL_ZERO));
        rq = rand_request();
        rq.command = su2qa_pkg::CMD_MUL;
        rq.b[0] = VAL_ONE;
        rq.b[1] = VAL_ZERO;
        rq.b[2] = VAL_ZERO;
        rq.b[3] = VAL_ZERO;
        send_request(rq);
        // complex scalar
        send_request(fill_request(su2qa_pkg::CMD_SCALE, VAL_ZERO, VAL_MAX, VAL_MAX));
        send_request(fill_request(su2qa_pkg::CMD_SCALE, VAL_ZERO, VAL_MIN, VAL_MIN));
        send_request(fill_request(su2qa_pkg::CMD_SCALE, VAL_ZERO, VAL_MAX, VAL_MIN));
        rq = rand_request();
        rq.command = su2qa_pkg::CMD_SCALE;
        rq.k_real = VAL_ONE;
        rq.k_imag = VAL_ZERO;
        send_request(rq);
        // conjugate, negating the most negative value
        send_request(fill_request(su2qa_pkg::CMD_CONJ, VAL_MIN, VAL_ZERO, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_CONJ, VAL_MAX, VAL_ZERO, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_CONJ, VAL_ZERO, VAL_ZERO, VAL_ZERO));
        // determinant and trace
        send_request(fill_request(su2qa_pkg::CMD_DET, VAL_MIN, VAL_ZERO, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_DET, VAL_MAX, VAL_ZERO, VAL_ZERO));
        send_request(fill_request(su2qa_pkg::CMD_DET, VAL_ONE >>> 1, VAL_MAX, VAL_MAX));
        send_request(fill_request(su2qa_pkg::CMD_TRACE, VAL_MIN, VAL_MAX, VAL_MAX));
        send_request(fill_request(su2qa_pkg::CMD_TRACE, VAL_MAX, VAL_MIN, VAL_MIN));
        send_request(fill_request(su2qa_pkg::CMD_TRACE, VAL_ONE, VAL_ZERO, VAL_ZERO));
        // unused codes
        rq = rand_request();
        rq.command = CMD_UNUSED_LO;
        send_request(rq);
        rq = fill_request(CMD_UNUSED_HI, VAL_MAX, VAL_MIN, VAL_MAX);
        send_request(rq);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 128 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            send_request(rand_request());
        end
        req_if.valid <= 1'b0;

        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("** su2_quaternion_alu_top: PASSED **");
        end else begin
            $display("** su2_quaternion_alu_top: FAILED **");
        end
        $finish;
    end

endmodule
